FILE: rtl/tsm_pkg.sv
// Shared types and constants for the touch ADC to screen mapper.
`default_nettype none

package tsm_pkg;

  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 320;
  localparam int ROT_SPAN      = 240;

  localparam int RAW_W  = 16;
  localparam int PT_W   = 9;
  localparam int AXIS_W = $clog2(((SCREEN_WIDTH > SCREEN_HEIGHT) ?
                                  SCREEN_WIDTH : SCREEN_HEIGHT) + 1);
  localparam int CALC_W = 13;
  localparam int CNT_W  = $clog2(RAW_W);

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_X_OFFSET = 3'd0,
    REG_Y_OFFSET = 3'd1,
    REG_X_SCALE  = 3'd2,
    REG_Y_SCALE  = 3'd3,
    REG_ROTATION = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_90   = 2'd1
  } rot_mode_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } sample_t;

  typedef struct packed {
    logic [PT_W-1:0] screen_x;
    logic [PT_W-1:0] screen_y;
    logic            stable;
    logic            mode_error;
  } point_t;

endpackage

`default_nettype wire

FILE: rtl/touch_adc_to_screen_mapper_top.sv
// Top level of the touch ADC to screen mapper: config registers, sequencer, shared divider.
//
// Usage:
//   sample (raw_x, raw_y) enters on sample_valid while sample_stall is low.
//   One mapped point leaves on point_valid; the receiver holds it with point_stall.
//   Each axis is (raw - offset) / scale through one shared restoring divider,
//   one quotient bit per cycle, then clamped; rotation and the stability test
//   follow in the finish step. Steps per sample: prep, divide and store for x,
//   then prep, divide and store for y, then finish. The idle step takes the
//   next sample, and the 16-step divider is used once per axis.
//   sample_stall is high while a sample is in work; a new sample is taken
//   while a finished point still waits in the output register.
//   If the receiver stalls, the next point waits in the finish step.
//   Registers sit on an APB port at byte address 4*index; pready is always high.
//   Reset (rst, synchronous) restores register defaults, clears the previous
//   point and empties the output register.
`default_nettype none

module touch_adc_to_screen_mapper_top
  import tsm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_stall,
  input  wire sample_t           sample,
  output logic                   point_valid,
  input  wire logic              point_stall,
  output point_t                 point,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_STORE,
    ST_FINISH
  } state_t;

  logic [RAW_W-1:0] x_offset, y_offset, x_scale, y_scale;
  logic [1:0]       rotation;
  reg_idx_t         cfg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset <= RAW_W'(2086);
      y_offset <= RAW_W'(2630);
      x_scale  <= RAW_W'(117);
      y_scale  <= RAW_W'(88);
      rotation <= ROT_NONE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_X_OFFSET: x_offset <= pwdata[RAW_W-1:0];
        REG_Y_OFFSET: y_offset <= pwdata[RAW_W-1:0];
        REG_X_SCALE:  x_scale  <= pwdata[RAW_W-1:0];
        REG_Y_SCALE:  y_scale  <= pwdata[RAW_W-1:0];
        REG_ROTATION: rotation <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_X_OFFSET: prdata = APB_DW'(x_offset);
      REG_Y_OFFSET: prdata = APB_DW'(y_offset);
      REG_X_SCALE:  prdata = APB_DW'(x_scale);
      REG_Y_SCALE:  prdata = APB_DW'(y_scale);
      REG_ROTATION: prdata = APB_DW'(rotation);
      default:      prdata = '0;
    endcase
  end

  state_t            state;
  logic              axis_sel;
  sample_t           raw;
  logic              pos;
  logic [RAW_W-1:0]  dvd;
  logic [RAW_W-1:0]  dvs;
  logic [RAW_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [AXIS_W-1:0] x_val, y_val;
  logic [PT_W-1:0]   prev_x, prev_y;

  logic [RAW_W-1:0]  op_raw, op_off, op_scale;
  logic [RAW_W:0]    sub_diff;
  logic [RAW_W:0]    rem_shift;
  logic [RAW_W+1:0]  trial;
  logic              qbit;
  logic [RAW_W-1:0]  limit;
  logic [AXIS_W-1:0] clamped;

  logic [CALC_W-1:0] xc, yc, rot_y;
  logic [CALC_W-1:0] nx_c, ny_c;
  logic [PT_W-1:0]   nx, ny, dx, dy;
  logic [4:0]        sq_sum;
  logic              stable_c, err_c;
  logic              out_free;
  logic              point_load;

  function automatic logic [3:0] sq2(input logic [1:0] v);
    case (v)
      2'd0:    sq2 = 4'd0;
      2'd1:    sq2 = 4'd1;
      2'd2:    sq2 = 4'd4;
      default: sq2 = 4'd9;
    endcase
  endfunction

  always_comb begin
    op_raw   = axis_sel ? raw.raw_y : raw.raw_x;
    op_off   = axis_sel ? y_offset  : x_offset;
    op_scale = axis_sel ? y_scale   : x_scale;
    sub_diff = {1'b0, op_raw} - {1'b0, op_off};

    rem_shift = {rem, dvd[RAW_W-1]};
    trial     = {1'b0, rem_shift} - {2'b00, dvs};
    qbit      = !trial[RAW_W+1];

    limit   = axis_sel ? RAW_W'(SCREEN_HEIGHT) : RAW_W'(SCREEN_WIDTH);
    if (!pos) begin
      clamped = '0;
    end else if (dvd > limit) begin
      clamped = limit[AXIS_W-1:0];
    end else begin
      clamped = dvd[AXIS_W-1:0];
    end

    xc    = CALC_W'(x_val);
    yc    = CALC_W'(y_val);
    rot_y = (xc > CALC_W'(ROT_SPAN)) ? '0 : CALC_W'(ROT_SPAN) - xc;
    err_c = 1'b0;
    if (rotation == ROT_90) begin
      nx_c = yc;
      ny_c = rot_y;
    end else begin
      nx_c  = xc;
      ny_c  = yc;
      err_c = (rotation != ROT_NONE);
    end
    nx = nx_c[PT_W-1:0];
    ny = ny_c[PT_W-1:0];

    dx = (prev_x >= nx) ? prev_x - nx : nx - prev_x;
    dy = (prev_y >= ny) ? prev_y - ny : ny - prev_y;
    sq_sum   = 5'(sq2(dx[1:0])) + 5'(sq2(dy[1:0]));
    stable_c = (dx <= PT_W'(3)) && (dy <= PT_W'(3)) && (sq_sum <= 5'd9);

    out_free   = !point_valid || !point_stall;
    point_load = (state == ST_FINISH) && out_free;
  end

  assign sample_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      axis_sel    <= 1'b0;
      point_valid <= 1'b0;
      prev_x      <= '0;
      prev_y      <= '0;
    end else begin
      if (point_load) begin
        point_valid <= 1'b1;
      end else if (point_valid && !point_stall) begin
        point_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            raw      <= sample;
            axis_sel <= 1'b0;
            state    <= ST_PREP;
          end
        end
        ST_PREP: begin
          pos   <= !sub_diff[RAW_W] && (sub_diff != '0);
          dvd   <= sub_diff[RAW_W-1:0];
          dvs   <= op_scale;
          rem   <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= qbit ? trial[RAW_W-1:0] : rem_shift[RAW_W-1:0];
          dvd <= {dvd[RAW_W-2:0], qbit};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(RAW_W - 1)) begin
            state <= ST_STORE;
          end
        end
        ST_STORE: begin
          if (axis_sel) begin
            y_val <= clamped;
            state <= ST_FINISH;
          end else begin
            x_val    <= clamped;
            axis_sel <= 1'b1;
            state    <= ST_PREP;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            point.screen_x   <= nx;
            point.screen_y   <= ny;
            point.stable     <= stable_c;
            point.mode_error <= err_c;
            prev_x           <= nx;
            prev_y           <= ny;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample accepted but block not busy");

  a_prev_tracks_point: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> (point.screen_x == prev_x) && (point.screen_y == prev_y))
    else $error("held point differs from stored previous point");

  a_point_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(point_valid) |-> $past(state) == ST_FINISH)
    else $error("point issued outside finish step");

endmodule

`default_nettype wire
